### rtl/lagg_pkg.sv
package lagg_pkg;

  typedef logic signed [15:0] score_t;
  typedef logic signed [7:0]  weight_t;

  // Scoring registers
  typedef struct packed {
    weight_t match_score;
    weight_t mismatch_score;
    weight_t gap_open;
    weight_t gap_extend;
  } cfg_t;

  // Row word handed from one cell to the next
  typedef struct packed {
    logic       valid;
    logic [7:0] sym;
    score_t     h;
    score_t     e;
    score_t     hdiag;
  } flow_t;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN = 2'd2;
  localparam logic [1:0] REG_GAP_EXT  = 2'd3;

  // Add an 8-bit weight and clamp to the signed 16-bit range
  function automatic score_t sat_add(score_t a, weight_t b);
    logic [16:0] s;
    s = {a[15], a} + {{9{b[7]}}, b};
    if (s[16] != s[15]) begin
      return s[16] ? 16'sh8000 : 16'sh7fff;
    end
    return score_t'(s[15:0]);
  endfunction

  function automatic score_t smax(score_t a, score_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/lagg_ram.sv
module lagg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/lagg_cell.sv
// One matrix column: holds its symbol, the H and F of the row above and its
// own best score; takes a row word from the left and hands it on to the right.
module lagg_cell #(
  parameter int PW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lagg_pkg::cfg_t  cfg_i,
  input  logic            clr_i,
  input  logic            active_i,
  input  logic            ld_en_i,
  input  logic [7:0]      col_sym_i,
  output logic [7:0]      col_sym_o,
  input  lagg_pkg::flow_t flow_i,
  input  logic [PW-1:0]   row_i,
  output lagg_pkg::flow_t flow_o,
  output logic [PW-1:0]   row_o,
  output lagg_pkg::score_t best_o,
  output logic [PW-1:0]   best_row_o
);

  logic [7:0]       col_sym_q;
  lagg_pkg::score_t hup_q, fup_q, best_q;
  logic [PW-1:0]    best_row_q;
  logic             flow_v_q;
  logic [7:0]       flow_sym_q;
  lagg_pkg::score_t flow_h_q, flow_e_q, flow_hdiag_q;
  logic [PW-1:0]    row_q;
  lagg_pkg::score_t f_val, e_val, d_val, h_val;
  lagg_pkg::weight_t sub_w;

  // cell recurrence
  always_comb begin
    sub_w = (flow_i.sym == col_sym_q) ? cfg_i.match_score : cfg_i.mismatch_score;
    f_val = lagg_pkg::smax(lagg_pkg::sat_add(fup_q, cfg_i.gap_extend),
                           lagg_pkg::sat_add(hup_q, cfg_i.gap_open));
    e_val = lagg_pkg::smax(lagg_pkg::sat_add(flow_i.e, cfg_i.gap_extend),
                           lagg_pkg::sat_add(flow_i.h, cfg_i.gap_open));
    d_val = lagg_pkg::sat_add(flow_i.hdiag, sub_w);
    h_val = lagg_pkg::smax(lagg_pkg::smax(d_val, f_val), lagg_pkg::smax(e_val, '0));
  end

  // column symbol shift line
  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      col_sym_q <= col_sym_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hup_q      <= '0;
      fup_q      <= '0;
      best_q     <= '0;
      best_row_q <= '0;
      flow_v_q   <= 1'b0;
    end else if (clr_i) begin
      hup_q      <= '0;
      fup_q      <= '0;
      best_q     <= '0;
      best_row_q <= '0;
      flow_v_q   <= 1'b0;
    end else begin
      flow_v_q <= flow_i.valid;
      if (flow_i.valid) begin
        hup_q <= h_val;
        fup_q <= f_val;
        // first (lowest) row wins on equal score
        if (active_i && (h_val > best_q)) begin
          best_q     <= h_val;
          best_row_q <= row_i;
        end
      end
    end
  end

  // word to the right neighbor
  always_ff @(posedge clk_i) begin
    if (flow_i.valid) begin
      flow_sym_q   <= flow_i.sym;
      flow_h_q     <= h_val;
      flow_e_q     <= e_val;
      flow_hdiag_q <= hup_q;
      row_q        <= row_i;
    end
  end

  assign col_sym_o  = col_sym_q;
  assign flow_o     = '{valid: flow_v_q, sym: flow_sym_q, h: flow_h_q, e: flow_e_q,
                        hdiag: flow_hdiag_q};
  assign row_o      = row_q;
  assign best_o     = best_q;
  assign best_row_o = best_row_q;

endmodule

### rtl/local_alignment_affine_gap_top.sv
// Local alignment with affine gaps on a chain of NCELL column cells.
// Loading: one symbol word per cycle while busy_o is low; busy_o rises once both
// sequences have ended. Compute: per pass, a setup state and ceil(ncols/NCELL)
// strips of columns, with the cell chain sweeping the longer sequence; for a nonzero score
// a second pass over the reversed prefixes finds the begin. done_o pulses one cycle.
// Reset: async active low; clears lengths, flags, scoring registers to defaults.
module local_alignment_affine_gap_top #(
  parameter int MAX_LEN = 1024,
  parameter int NCELL   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        kind_i,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  output logic        done_o,
  output logic [14:0] best_score_o,
  output logic [10:0] a_begin_o,
  output logic [10:0] a_end_o,
  output logic [10:0] b_begin_o,
  output logic [10:0] b_end_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int KW = $clog2(NCELL);
  localparam int CW = $clog2(MAX_LEN + NCELL + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_STREAM = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_MERGE  = 3'd5;
  localparam logic [2:0] ST_NEXT   = 3'd6;

  logic [2:0] state_q, state_d;

  lagg_pkg::cfg_t cfg_q;
  logic [PW-1:0]  len_a_q, len_b_q;
  logic           done_a_q, done_b_q;
  logic [PW-1:0]  pl_a_q, pl_b_q;
  logic           rev_q, a_is_col_q;
  logic [PW-1:0]  nrows_q, ncols_q;
  logic [CW-1:0]  base_q;
  logic [KW:0]    ld_q;
  logic [KW-1:0]  mk_q;
  logic [PW-1:0]  row_q;
  logic           feed_v_q;
  logic [PW-1:0]  feed_row_q;
  lagg_pkg::score_t prev_h_q;
  lagg_pkg::score_t gbest_q;
  logic [PW-1:0]  grow_q, gcol_q;
  lagg_pkg::score_t score_q;
  logic [PW-1:0]  a_end_q, b_end_q;

  logic           done_q;
  logic [14:0]    out_score_q;
  logic [10:0]    out_ab_q, out_ae_q, out_bb_q, out_be_q;

  // ---------------------------------------------------------------------------
  // accept and sequence stores
  logic accept;
  logic we_a, we_b;
  logic [AW-1:0] raddr_a, raddr_b, row_addr, col_addr;
  logic [7:0] rdata_a, rdata_b, row_sym, col_sym;
  logic [CW-1:0] colp;

  // busy from the cycle after the word that completes a job
  assign busy_o = (state_q != ST_IDLE) || (done_a_q && done_b_q);
  assign accept = start_i && !busy_o;
  assign we_a = accept && !kind_i && !done_a_q && (len_a_q < PW'(MAX_LEN));
  assign we_b = accept &&  kind_i && !done_b_q && (len_b_q < PW'(MAX_LEN));

  // 1-based row/column position to store address (reversed in the back pass)
  assign colp     = base_q + CW'(ld_q) + CW'(1);
  assign row_addr = rev_q ? AW'(nrows_q - row_q) : AW'(row_q - PW'(1));
  assign col_addr = rev_q ? AW'(CW'(ncols_q) - colp) : AW'(base_q + CW'(ld_q));
  assign raddr_a  = a_is_col_q ? col_addr : row_addr;
  assign raddr_b  = a_is_col_q ? row_addr : col_addr;
  assign row_sym  = a_is_col_q ? rdata_b : rdata_a;
  assign col_sym  = a_is_col_q ? rdata_a : rdata_b;

  lagg_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len_a_q[AW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  lagg_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (len_b_q[AW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // ---------------------------------------------------------------------------
  // strip boundary: H and E of the last column, one entry per row
  lagg_pkg::flow_t flow [NCELL+1];
  logic [PW-1:0]   frow [NCELL+1];
  logic [7:0]      csym [NCELL+1];
  lagg_pkg::score_t cbest [NCELL];
  logic [PW-1:0]   cbrow [NCELL];
  logic [NCELL-1:0] act;
  logic [31:0]     bnd_rdata;
  logic            strip_clr, ld_en;
  lagg_pkg::score_t left_h, left_e;

  lagg_ram #(.WIDTH(32), .DEPTH(MAX_LEN + 1)) u_bnd (
    .clk_i   (clk_i),
    .we_i    (flow[NCELL].valid),
    .waddr_i (frow[NCELL]),
    .wdata_i ({flow[NCELL].h, flow[NCELL].e}),
    .raddr_i (row_q),
    .rdata_o (bnd_rdata)
  );

  // first strip sees the zero column
  assign left_h = (base_q == '0) ? '0 : lagg_pkg::score_t'(bnd_rdata[31:16]);
  assign left_e = (base_q == '0) ? '0 : lagg_pkg::score_t'(bnd_rdata[15:0]);

  assign flow[0].valid = feed_v_q;
  assign flow[0].sym   = row_sym;
  assign flow[0].h     = left_h;
  assign flow[0].e     = left_e;
  assign flow[0].hdiag = prev_h_q;
  assign frow[0]       = feed_row_q;
  assign csym[NCELL]   = col_sym;

  assign strip_clr = (state_q == ST_LOAD) && (ld_q == '0);
  assign ld_en     = (state_q == ST_LOAD) && (ld_q != '0);

  // ---------------------------------------------------------------------------
  // cell chain
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    assign act[k] = (base_q + CW'(k)) < CW'(ncols_q);

    lagg_cell #(.PW(PW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (cfg_q),
      .clr_i      (strip_clr),
      .active_i   (act[k]),
      .ld_en_i    (ld_en),
      .col_sym_i  (csym[k+1]),
      .col_sym_o  (csym[k]),
      .flow_i     (flow[k]),
      .row_i      (frow[k]),
      .flow_o     (flow[k+1]),
      .row_o      (frow[k+1]),
      .best_o     (cbest[k]),
      .best_row_o (cbrow[k])
    );
  end

  // ---------------------------------------------------------------------------
  // pass results
  logic [PW-1:0] pos_a, pos_b;
  logic          strips_done;

  assign pos_a       = a_is_col_q ? gcol_q : grow_q;
  assign pos_b       = a_is_col_q ? grow_q : gcol_q;
  assign strips_done = (base_q + CW'(NCELL)) >= CW'(ncols_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (done_a_q && done_b_q) state_d = ST_SETUP;
      end
      ST_SETUP:  state_d = ST_LOAD;
      ST_LOAD: begin
        if (ld_q == (KW+1)'(NCELL)) state_d = ST_STREAM;
      end
      ST_STREAM: begin
        if (row_q == nrows_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (ld_q == (KW+1)'(NCELL)) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (mk_q == KW'(NCELL - 1)) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (!strips_done) state_d = ST_LOAD;
        else if (!rev_q && (gbest_q != '0)) state_d = ST_SETUP;
        else state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= '{match_score: 8'sd3, mismatch_score: -8'sd3,
                    gap_open: -8'sd6, gap_extend: -8'sd1};
      len_a_q  <= '0;
      len_b_q  <= '0;
      done_a_q <= 1'b0;
      done_b_q <= 1'b0;
      rev_q    <= 1'b0;
      ld_q     <= '0;
      mk_q     <= '0;
      row_q    <= '0;
      feed_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= 1'b0;
      feed_v_q <= (state_q == ST_STREAM);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          lagg_pkg::REG_MATCH:    cfg_q.match_score    <= cfg_data_i;
          lagg_pkg::REG_MISMATCH: cfg_q.mismatch_score <= cfg_data_i;
          lagg_pkg::REG_GAP_OPEN: cfg_q.gap_open       <= cfg_data_i;
          lagg_pkg::REG_GAP_EXT:  cfg_q.gap_extend     <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept) begin
        if (!kind_i && !done_a_q) begin
          if (we_a) len_a_q <= len_a_q + PW'(1);
          if (last_i) done_a_q <= 1'b1;
        end
        if (kind_i && !done_b_q) begin
          if (we_b) len_b_q <= len_b_q + PW'(1);
          if (last_i) done_b_q <= 1'b1;
        end
      end

      case (state_q)
        ST_IDLE: begin
          rev_q <= 1'b0;
        end
        ST_SETUP: begin
          ld_q <= '0;
        end
        ST_LOAD: begin
          ld_q <= ld_q + (KW+1)'(1);
          if (ld_q == (KW+1)'(NCELL)) row_q <= PW'(1);
        end
        ST_STREAM: begin
          ld_q <= '0;
          if (row_q != nrows_q) row_q <= row_q + PW'(1);
        end
        ST_DRAIN: begin
          ld_q <= ld_q + (KW+1)'(1);
          mk_q <= '0;
        end
        ST_MERGE: begin
          mk_q <= mk_q + KW'(1);
        end
        ST_NEXT: begin
          ld_q <= '0;
          if (strips_done) begin
            if (!rev_q && (gbest_q != '0)) begin
              rev_q <= 1'b1;
            end else begin
              done_q   <= 1'b1;
              len_a_q  <= '0;
              len_b_q  <= '0;
              done_a_q <= 1'b0;
              done_b_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (feed_v_q) prev_h_q <= left_h;
    feed_row_q <= row_q;

    case (state_q)
      ST_IDLE: begin
        pl_a_q <= len_a_q;
        pl_b_q <= len_b_q;
      end
      ST_SETUP: begin
        a_is_col_q <= pl_a_q < pl_b_q;
        nrows_q    <= (pl_a_q < pl_b_q) ? pl_b_q : pl_a_q;
        ncols_q    <= (pl_a_q < pl_b_q) ? pl_a_q : pl_b_q;
        base_q     <= '0;
        gbest_q    <= '0;
        grow_q     <= '0;
        gcol_q     <= '0;
      end
      ST_LOAD: begin
        prev_h_q <= '0;
      end
      ST_MERGE: begin
        // strict compare keeps the lowest column on equal score
        if (act[mk_q] && (cbest[mk_q] > gbest_q)) begin
          gbest_q <= cbest[mk_q];
          grow_q  <= cbrow[mk_q];
          gcol_q  <= PW'(base_q + CW'(mk_q) + CW'(1));
        end
      end
      ST_NEXT: begin
        if (!strips_done) begin
          base_q <= base_q + CW'(NCELL);
        end else if (!rev_q) begin
          score_q <= gbest_q;
          a_end_q <= pos_a;
          b_end_q <= pos_b;
          pl_a_q  <= pos_a;
          pl_b_q  <= pos_b;
          if (gbest_q == '0) begin
            out_score_q <= '0;
            out_ab_q    <= '0;
            out_ae_q    <= '0;
            out_bb_q    <= '0;
            out_be_q    <= '0;
          end
        end else begin
          out_score_q <= score_q[14:0];
          out_ab_q    <= 11'(a_end_q - pos_a);
          out_ae_q    <= 11'(a_end_q);
          out_bb_q    <= 11'(b_end_q - pos_b);
          out_be_q    <= 11'(b_end_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign best_score_o = out_score_q;
  assign a_begin_o    = out_ab_q;
  assign a_end_o      = out_ae_q;
  assign b_begin_o    = out_bb_q;
  assign b_end_o      = out_be_q;

  // ---------------------------------------------------------------------------
  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result word while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_feed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed_v_q |-> (state_q == ST_STREAM || state_q == ST_DRAIN))
    else $error("row word fed outside streaming");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) |-> (row_q != '0 && row_q <= nrows_q))
    else $error("row counter out of range");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Scoreboard: shadows the aligner's loading state, predicts the alignment
// word when a job completes, and checks returned words in order.
class align_scoreboard;
  localparam int MAXL = 1024;

  typedef struct {
    int unsigned score;
    int unsigned a_begin;
    int unsigned a_end;
    int unsigned b_begin;
    int unsigned b_end;
  } align_word_t;

  align_word_t expected_q[$];
  int fails;

  logic [7:0] store_a [MAXL];
  logic [7:0] store_b [MAXL];
  int unsigned len_a, len_b;
  bit done_a, done_b;
  int w_match, w_mismatch, w_open, w_ext;

  function new();
    fails = 0;
    len_a = 0;
    len_b = 0;
    done_a = 0;
    done_b = 0;
    w_match = 3;
    w_mismatch = -3;
    w_open = -6;
    w_ext = -1;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      lagg_pkg::REG_MATCH:    w_match    = int'($signed(val));
      lagg_pkg::REG_MISMATCH: w_mismatch = int'($signed(val));
      lagg_pkg::REG_GAP_OPEN: w_open     = int'($signed(val));
      lagg_pkg::REG_GAP_EXT:  w_ext      = int'($signed(val));
      default: ;
    endcase
  endfunction

  static function int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // One affine-gap sweep; longer sequence on rows, A on rows for equal lengths.
  // Returns the best score and its one-based A and B positions.
  function int sweep(logic [7:0] sa [MAXL], int unsigned la,
                     logic [7:0] sb [MAXL], int unsigned lb,
                     output int unsigned pa, output int unsigned pb);
    int hcol [MAXL+1];
    int fcol [MAXL+1];
    int best, brow, bcol, nrows, ncols;
    int hdiag, hleft, eleft, hup, f, e, d, h;
    bit a_col;
    logic [7:0] rc, cc;
    a_col = la < lb;
    nrows = a_col ? lb : la;
    ncols = a_col ? la : lb;
    for (int k = 0; k <= MAXL; k++) begin
      hcol[k] = 0;
      fcol[k] = 0;
    end
    best = 0;
    brow = 0;
    bcol = 0;
    for (int i = 1; i <= nrows; i++) begin
      hdiag = 0;
      hleft = 0;
      eleft = 0;
      rc = a_col ? sb[i-1] : sa[i-1];
      for (int j = 1; j <= ncols; j++) begin
        cc = a_col ? sa[j-1] : sb[j-1];
        hup = hcol[j];
        f = clamp16(fcol[j] + w_ext);
        if (clamp16(hup + w_open) > f) f = clamp16(hup + w_open);
        e = clamp16(eleft + w_ext);
        if (clamp16(hleft + w_open) > e) e = clamp16(hleft + w_open);
        d = clamp16(hdiag + ((rc == cc) ? w_match : w_mismatch));
        h = 0;
        if (d > h) h = d;
        if (f > h) h = f;
        if (e > h) h = e;
        hdiag = hup;
        hcol[j] = h;
        fcol[j] = f;
        eleft = e;
        hleft = h;
        if (h > 0 && (h > best || (h == best && j < bcol))) begin
          best = h;
          brow = i;
          bcol = j;
        end
      end
    end
    pa = a_col ? bcol : brow;
    pb = a_col ? brow : bcol;
    return best;
  endfunction

  // Accepted input word: update loading state, predict on job completion
  function void note_word(bit kind, logic [7:0] sym, bit last);
    align_word_t w;
    logic [7:0] rev_a [MAXL];
    logic [7:0] rev_b [MAXL];
    int unsigned ra, rb;
    int s;
    if (kind == 1'b0) begin
      if (done_a) return;
      if (len_a < MAXL) begin
        store_a[len_a] = sym;
        len_a++;
      end
      if (last) done_a = 1;
    end else begin
      if (done_b) return;
      if (len_b < MAXL) begin
        store_b[len_b] = sym;
        len_b++;
      end
      if (last) done_b = 1;
    end
    if (!(done_a && done_b)) return;
    w = '{default: 0};
    w.score = sweep(store_a, len_a, store_b, len_b, w.a_end, w.b_end);
    if (w.score == 0) begin
      w.a_end = 0;
      w.b_end = 0;
    end else begin
      for (int k = 0; k < MAXL; k++) begin
        rev_a[k] = (k < w.a_end) ? store_a[w.a_end-1-k] : 8'h00;
        rev_b[k] = (k < w.b_end) ? store_b[w.b_end-1-k] : 8'h00;
      end
      s = sweep(rev_a, w.a_end, rev_b, w.b_end, ra, rb);
      w.a_begin = w.a_end - ra;
      w.b_begin = w.b_end - rb;
    end
    expected_q.push_back(w);
    len_a = 0;
    len_b = 0;
    done_a = 0;
    done_b = 0;
  endfunction

  function void check_word(logic [14:0] score, logic [10:0] ab, logic [10:0] ae,
                           logic [10:0] bb, logic [10:0] be);
    align_word_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected word score=%0d a=%0d..%0d b=%0d..%0d",
               $time, score, ab, ae, bb, be);
      fails++;
      return;
    end
    w = expected_q.pop_front();
    if (score !== 15'(w.score)) begin
      $display("%0t: best_score exp %0d got %0d", $time, w.score, score);
      fails++;
    end
    if (ab !== 11'(w.a_begin)) begin
      $display("%0t: a_begin exp %0d got %0d", $time, w.a_begin, ab);
      fails++;
    end
    if (ae !== 11'(w.a_end)) begin
      $display("%0t: a_end exp %0d got %0d", $time, w.a_end, ae);
      fails++;
    end
    if (bb !== 11'(w.b_begin)) begin
      $display("%0t: b_begin exp %0d got %0d", $time, w.b_begin, bb);
      fails++;
    end
    if (be !== 11'(w.b_end)) begin
      $display("%0t: b_end exp %0d got %0d", $time, w.b_end, be);
      fails++;
    end
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        start_i;
  logic        busy_o;
  logic        kind_i;
  logic [7:0]  symbol_i;
  logic        last_i;
  logic        done_o;
  logic [14:0] best_score_o;
  logic [10:0] a_begin_o;
  logic [10:0] a_end_o;
  logic [10:0] b_begin_o;
  logic [10:0] b_end_o;

  align_scoreboard sb;
  int unsigned idle_cycles;
  bit          accepted;
  int          sent_words;

  local_alignment_affine_gap_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .kind_i, .symbol_i, .last_i, .done_o, .best_score_o, .a_begin_o, .a_end_o,
    .b_begin_o, .b_end_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor: done_o is a one-cycle strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_word(best_score_o, a_begin_o, a_end_o, b_begin_o, b_end_o);
    end
  end

  // Watchdog on cycles without any accepted word or result
  always @(posedge clk_i) begin
    if (accepted || (rst_ni && done_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      accepted = 1'b0;
    end
  endtask

  // Drive one symbol word; busy only moves at rising edges so the
  // falling-edge value tells whether the next edge accepts.
  task automatic send_word(bit kind, logic [7:0] sym, bit last);
    idle(gap_len());
    @(negedge clk_i);
    start_i = 1'b1;
    kind_i = kind;
    symbol_i = sym;
    last_i = last;
    accepted = 1'b0;
    while (busy_o) begin
      @(negedge clk_i);
    end
    accepted = 1'b1;
    @(posedge clk_i);
    sb.note_word(kind, sym, last);
    sent_words++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    accepted = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [7:0] m, logic [7:0] mm, logic [7:0] go, logic [7:0] ge);
    wait_idle();
    write_reg(lagg_pkg::REG_MATCH, m);
    write_reg(lagg_pkg::REG_MISMATCH, mm);
    write_reg(lagg_pkg::REG_GAP_OPEN, go);
    write_reg(lagg_pkg::REG_GAP_EXT, ge);
  endtask

  // Weight in [-128, hi], extremes favored
  function automatic logic [7:0] pick_weight(int hi);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h80;
    if (r == 1) return 8'(hi);
    return 8'($urandom_range(hi + 128) - 128);
  endfunction

  // Symbols drawn near a base byte so that matches are common
  function automatic logic [7:0] pick_sym(logic [7:0] base, int spread);
    if ($urandom_range(19) == 0) return 8'($urandom);
    return base ^ 8'($urandom_range(spread));
  endfunction

  // One job: la A symbols and lb B symbols interleaved at random; the last
  // flag goes on the final symbol of each. junk adds ignored words after
  // one sequence completes.
  task automatic run_job(int la, int lb, logic [7:0] base, int spread, bit junk);
    int ia, ib;
    bit pick_a;
    ia = 0;
    ib = 0;
    while (ia < la || ib < lb) begin
      pick_a = (ib >= lb) ? 1'b1 : (ia >= la) ? 1'b0 : 1'($urandom);
      if (pick_a) begin
        send_word(1'b0, pick_sym(base, spread), ia == la - 1);
        ia++;
        if (junk && ia == la && ib < lb) send_word(1'b0, 8'($urandom), 1'($urandom));
      end else begin
        send_word(1'b1, pick_sym(base, spread), ib == lb - 1);
        ib++;
        if (junk && ib == lb && ia < la) send_word(1'b1, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    int la, lb, job;
    sb = new();
    idle_cycles = 0;
    accepted = 1'b0;
    sent_words = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lagg_pkg::REG_MATCH;
    cfg_data_i = 8'h00;
    start_i = 1'b0;
    kind_i = 1'b0;
    symbol_i = 8'h00;
    last_i = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: default weights, single symbols, equal lengths, ignored words
    send_word(1'b0, 8'hff, 1'b1);
    send_word(1'b1, 8'hff, 1'b1);
    send_word(1'b1, 8'h00, 1'b1);
    send_word(1'b1, 8'h00, 1'b1);
    send_word(1'b0, 8'h55, 1'b0);
    send_word(1'b0, 8'haa, 1'b1);
    send_word(1'b0, 8'h00, 1'b1);
    run_job(4, 4, 8'h41, 1, 1'b1);
    run_job(2, 6, 8'h30, 3, 1'b0);

    // Zero score: matches penalized
    write_all(8'h80, 8'h80, 8'h80, 8'h80);
    run_job(3, 3, 8'h00, 1, 1'b0);
    // Strongest match, free gaps
    write_all(8'h7f, 8'h80, 8'h00, 8'h00);
    run_job(5, 7, 8'hc3, 1, 1'b0);
    write_all(8'h80, 8'h7f, 8'h00, 8'h80);
    run_job(6, 3, 8'h10, 3, 1'b0);

    // Full A store (extra symbol dropped, its last flag still counts) and
    // score saturation against a long identical B
    write_all(8'h7f, 8'h80, 8'h80, 8'h80);
    run_job(1025, 260, 8'h5a, 0, 1'b0);

    // Random jobs until the word budget is used up
    write_all(8'h03, 8'hfd, 8'hfa, 8'hff);
    job = 0;
    while (sent_words < 1600) begin
      if (job % 8 == 7) begin
        write_all(pick_weight(127), pick_weight(127), pick_weight(0), pick_weight(0));
      end
      if ($urandom_range(24) == 0) begin
        la = $urandom_range(90, 20);
        lb = $urandom_range(90, 20);
      end else begin
        la = $urandom_range(14, 1);
        lb = $urandom_range(14, 1);
      end
      run_job(la, lb, 8'($urandom), ($urandom_range(3) == 0) ? 255 : 3,
              $urandom_range(5) == 0);
      job++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
